### src/iso_timestamp_year_offset_parser_assert.svh
// assertion macros shared by the parser modules
// each expects clk and arst_n in the scope where it is used
`ifndef ISO_TIMESTAMP_YEAR_OFFSET_PARSER_ASSERT_SVH
`define ISO_TIMESTAMP_YEAR_OFFSET_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define ITS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition must never be seen
`define ITS_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ITS_ASSERT(name, prop, msg)
`define ITS_ASSERT_NEVER(name, cond, msg)
`endif

`endif

### src/its_pkg.sv
package its_pkg;

	localparam int CHAR_W   = 8;
	localparam int POS_W    = 5;
	localparam int YEAR_W   = 12;
	localparam int OFFSET_W = 11;
	localparam int YACC_W   = 14;
	localparam int HMACC_W  = 7;
	localparam int OFFSUM_W = 13;
	localparam int DIGIT_W  = 4;

	localparam int QUEUE_DEPTH_DEF = 2;

	// character positions of the timestamp
	localparam logic [POS_W-1:0] POS_IDLE     = 5'd24;
	localparam logic [POS_W-1:0] POS_YEAR_END = 5'd4;
	localparam logic [POS_W-1:0] POS_DASH_MON = 5'd4;
	localparam logic [POS_W-1:0] POS_DASH_DAY = 5'd7;
	localparam logic [POS_W-1:0] POS_T        = 5'd10;
	localparam logic [POS_W-1:0] POS_COLON_M  = 5'd13;
	localparam logic [POS_W-1:0] POS_COLON_S  = 5'd16;
	localparam logic [POS_W-1:0] POS_SIGN     = 5'd19;
	localparam logic [POS_W-1:0] POS_HOUR_HI  = 5'd20;
	localparam logic [POS_W-1:0] POS_HOUR_LO  = 5'd21;
	localparam logic [POS_W-1:0] POS_MIN_HI   = 5'd22;
	localparam logic [POS_W-1:0] POS_MIN_LO   = 5'd23;

	// ascii codes
	localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	// result limits
	localparam logic [YACC_W-1:0]   YEAR_MIN   = 14'd2000;
	localparam logic [YACC_W-1:0]   YEAR_MAX   = 14'd2199;
	localparam logic [OFFSUM_W-1:0] OFFSET_MAX = 13'(14 * 60);

	// operation handed from the classifier to the accumulator
	typedef enum logic [2:0] {
		OP_SKIP,
		OP_BAD,
		OP_YEAR,
		OP_HOUR,
		OP_MIN,
		OP_NEG
	} its_op_t;

	typedef struct packed {
		its_op_t              op;
		logic [DIGIT_W-1:0]   digit;
		logic                 restart;
		logic                 last;
	} its_entry_t;

endpackage

### src/its_if.sv
interface its_char_if import its_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_byte;
	logic              first_byte;

	modport source (output valid, output char_byte, output first_byte, input ready);
	modport sink (input valid, input char_byte, input first_byte, output ready);
endinterface

interface its_result_if import its_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [YEAR_W-1:0]          year_value;
	logic signed [OFFSET_W-1:0] offset_minutes;

	modport source (output valid, output year_value, output offset_minutes, input ready);
	modport sink (input valid, input year_value, input offset_minutes, output ready);
endinterface

### src/iso_timestamp_year_offset_parser.sv
// result: the byte at position 23 is queued, then popped into the output register
// throughput: one byte per cycle while the queue has room; the classifier, the queue and the
// accumulator each move one transaction a cycle, output register in the last stage
// a stalled output holds the final byte and all behind it; the queue keeps taking bytes until full
// reset: asynchronous active low, position idle until a first flag, queue empty,
// accumulators and output valid cleared
module iso_timestamp_year_offset_parser import its_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	its_char_if.sink     chars,
	its_result_if.source result
);

	logic       push;
	logic       pop;
	logic       full;
	logic       empty;
	its_entry_t push_entry;
	its_entry_t pop_entry;

	// classify bytes and track position
	its_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue
	its_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (empty)
	);

	// accumulate and emit the result
	its_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_entry (pop_entry),
		.pop       (pop),
		.result    (result)
	);

endmodule

### src/its_front.sv
module its_front import its_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	its_char_if.sink   chars,
	input  logic       full,
	output logic       push,
	output its_entry_t push_entry
);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_eff;
	logic             accept;
	logic             active;
	logic             is_digit;
	its_op_t          op;

	assign chars.ready = !full;
	assign accept      = chars.valid && chars.ready;

	// a first flag restarts at position zero
	assign pos_eff = chars.first_byte ? '0 : pos_q;
	assign active  = pos_eff < POS_IDLE;
	assign push    = accept && active;

	assign is_digit = (chars.char_byte >= CHAR_ZERO) && (chars.char_byte <= CHAR_NINE);

	// classify the byte against the expected shape
	always_comb begin
		case (pos_eff)
			POS_DASH_MON, POS_DASH_DAY: begin
				op = (chars.char_byte == CHAR_MINUS) ? OP_SKIP : OP_BAD;
			end
			POS_T: begin
				op = (chars.char_byte == CHAR_T) ? OP_SKIP : OP_BAD;
			end
			POS_COLON_M, POS_COLON_S: begin
				op = (chars.char_byte == CHAR_COLON) ? OP_SKIP : OP_BAD;
			end
			POS_SIGN: begin
				if (chars.char_byte == CHAR_MINUS) begin
					op = OP_NEG;
				end else if (chars.char_byte == CHAR_PLUS) begin
					op = OP_SKIP;
				end else begin
					op = OP_BAD;
				end
			end
			default: begin
				if (!is_digit) begin
					op = OP_BAD;
				end else if (pos_eff < POS_YEAR_END) begin
					op = OP_YEAR;
				end else if (pos_eff == POS_HOUR_HI || pos_eff == POS_HOUR_LO) begin
					op = OP_HOUR;
				end else if (pos_eff == POS_MIN_HI || pos_eff == POS_MIN_LO) begin
					op = OP_MIN;
				end else begin
					op = OP_SKIP;
				end
			end
		endcase
	end

	assign push_entry.op      = op;
	assign push_entry.digit   = DIGIT_W'(chars.char_byte - CHAR_ZERO);
	assign push_entry.restart = chars.first_byte;
	assign push_entry.last    = (pos_eff == POS_MIN_LO);

	// position counter, idle at the end until the next first flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
		end else if (push) begin
			pos_q <= pos_eff + POS_W'(1);
		end
	end

`include "iso_timestamp_year_offset_parser_assert.svh"

	`ITS_ASSERT_NEVER(a_no_push_idle, push && pos_q == POS_IDLE && !chars.first_byte, "push while idle")
	`ITS_ASSERT(a_pos_range, pos_q <= POS_IDLE, "position out of range")

endmodule

### src/its_queue.sv
module its_queue import its_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  its_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output its_entry_t pop_entry,
	output logic       empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	its_entry_t       slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_FULL);
	assign empty     = (count_q == '0);
	assign pop_entry = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`include "iso_timestamp_year_offset_parser_assert.svh"

	`ITS_ASSERT_NEVER(a_pop_empty, pop && empty, "pop from empty queue")
	`ITS_ASSERT_NEVER(a_push_full, push && full, "push into full queue")

endmodule

### src/its_back.sv
module its_back import its_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  its_entry_t pop_entry,
	output logic       pop,
	its_result_if.source result
);

	logic               shape_q;
	logic [YACC_W-1:0]  year_q;
	logic [HMACC_W-1:0] hours_q;
	logic [HMACC_W-1:0] mins_q;
	logic               neg_q;

	logic               shape_b, shape_n;
	logic [YACC_W-1:0]  year_b, year_n;
	logic [HMACC_W-1:0] hours_b, hours_n;
	logic [HMACC_W-1:0] mins_b, mins_n;
	logic               neg_b, neg_n;

	logic [OFFSUM_W-1:0]        off_sum;
	logic                       year_ok;
	logic [YEAR_W-1:0]          year_out;
	logic signed [OFFSET_W-1:0] off_out;
	logic                       out_valid_q;

	// a transaction that ends a timestamp waits for a free output slot
	assign pop = !empty && (!pop_entry.last || !out_valid_q || result.ready);

	// start from a clean parse on restart
	always_comb begin
		if (pop_entry.restart) begin
			shape_b = 1'b1;
			year_b  = '0;
			hours_b = '0;
			mins_b  = '0;
			neg_b   = 1'b0;
		end else begin
			shape_b = shape_q;
			year_b  = year_q;
			hours_b = hours_q;
			mins_b  = mins_q;
			neg_b   = neg_q;
		end
	end

	// apply the classified operation
	always_comb begin
		shape_n = shape_b;
		year_n  = year_b;
		hours_n = hours_b;
		mins_n  = mins_b;
		neg_n   = neg_b;
		case (pop_entry.op)
			OP_BAD:  shape_n = 1'b0;
			OP_YEAR: year_n  = YACC_W'(year_b * YACC_W'(10) + YACC_W'(pop_entry.digit));
			OP_HOUR: hours_n = HMACC_W'(hours_b * HMACC_W'(10) + HMACC_W'(pop_entry.digit));
			OP_MIN:  mins_n  = HMACC_W'(mins_b * HMACC_W'(10) + HMACC_W'(pop_entry.digit));
			OP_NEG:  neg_n   = 1'b1;
			default: ;
		endcase
	end

	// final range checks
	assign off_sum  = OFFSUM_W'(hours_n) * OFFSUM_W'(60) + OFFSUM_W'(mins_n);
	assign year_ok  = shape_n && (year_n >= YEAR_MIN) && (year_n <= YEAR_MAX);
	assign year_out = year_ok ? year_n[YEAR_W-1:0] : '0;
	always_comb begin
		if (year_ok && off_sum <= OFFSET_MAX) begin
			off_out = neg_n ? -$signed(off_sum[OFFSET_W-1:0]) : $signed(off_sum[OFFSET_W-1:0]);
		end else begin
			off_out = '0;
		end
	end

	// accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= 1'b0;
			year_q  <= '0;
			hours_q <= '0;
			mins_q  <= '0;
			neg_q   <= 1'b0;
		end else if (pop) begin
			shape_q <= shape_n;
			year_q  <= year_n;
			hours_q <= hours_n;
			mins_q  <= mins_n;
			neg_q   <= neg_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && pop_entry.last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_entry.last) begin
			result.year_value     <= year_out;
			result.offset_minutes <= off_out;
		end
	end

	assign result.valid = out_valid_q;

`include "iso_timestamp_year_offset_parser_assert.svh"

	`ITS_ASSERT_NEVER(a_no_overwrite, pop && pop_entry.last && out_valid_q && !result.ready,
		"pending result overwritten")
	`ITS_ASSERT(a_result_after_last, $rose(out_valid_q) |-> $past(pop && pop_entry.last),
		"result without a final byte")

endmodule

### tb/iso_timestamp_year_offset_parser_tb.sv
module iso_timestamp_year_offset_parser_tb;
	import its_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int STAMP_LEN    = 24;
	localparam int RANDOM_CHARS = 1600;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int RUN_LIMIT    = 5_000_000;
	localparam int NUM_ROWS     = 18;

	typedef struct {
		logic [YEAR_W-1:0]          year;
		logic signed [OFFSET_W-1:0] offset;
	} stamp_result_t;

	// one directed timestamp; typed rows carry the result read off by hand
	typedef struct {
		string text;
		bit    lead_first;
		bit    typed;
		int    year;
		int    offset;
	} stamp_row_t;

	stamp_row_t stamp_rows [NUM_ROWS] = '{
		'{"17:9",                        1'b0, 1'b0, 0,    0},
		'{"2000-01-01T00:00:00+0000",    1'b1, 1'b1, 2000, 0},
		'{"2199-12-31T23:59:59-1400",    1'b1, 1'b1, 2199, -840},
		'{"2199-12-31T23:59:59+1400",    1'b1, 1'b1, 2199, 840},
		'{"1999-12-31T23:59:59+0100",    1'b1, 1'b1, 0,    0},
		'{"2200-01-01T00:00:00+0100",    1'b1, 1'b1, 0,    0},
		'{"0000-00-00T00:00:00-0000",    1'b1, 1'b1, 0,    0},
		'{"9999-99-99T99:99:99+9999",    1'b1, 1'b1, 0,    0},
		'{"20a4-06-15T12:30:45+0530",    1'b1, 1'b1, 0,    0},
		'{"2024-06-15X12:30:45+0530",    1'b1, 1'b1, 0,    0},
		'{"2024/06-15T12:30:45+0530",    1'b1, 1'b1, 0,    0},
		'{"2024-06-15T12:30:45*0530",    1'b1, 1'b1, 0,    0},
		'{"2024-06-15T12:30:45+05a0",    1'b1, 1'b1, 0,    0},
		'{"2024-06-15T12:30:45+1401",    1'b1, 1'b1, 2024, 0},
		'{"2024-06-15T12:30:45+0099",    1'b1, 1'b1, 2024, 99},
		'{"2031-02-28T0",                1'b1, 1'b0, 0,    0},
		'{"2087-11-03T07:45:00-0345xyz", 1'b1, 1'b0, 0,    0},
		'{"2123-04-05T06:07:08+0910",    1'b1, 1'b0, 0,    0}
	};

	logic clk = 1'b0;
	logic arst_n;

	its_char_if   chars_if ();
	its_result_if result_if ();

	iso_timestamp_year_offset_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if.sink),
		.result (result_if.source)
	);

	// parser shadow state
	logic [POS_W-1:0]   at_pos   = POS_IDLE;
	logic               stamp_ok = 1'b0;
	logic [YACC_W-1:0]  year_sum = '0;
	logic [HMACC_W-1:0] hour_sum = '0;
	logic [HMACC_W-1:0] min_sum  = '0;
	logic               west     = 1'b0;

	stamp_result_t pending_stamps [$];
	stamp_result_t oldest;
	logic [CHAR_W-1:0] stamp_buf [STAMP_LEN];

	int  errors        = 0;
	int  chars_sent    = 0;
	int  stamp_chars   = 0;
	int  stamps_sent   = 0;
	int  results_seen  = 0;
	int  squeezes      = 0;
	bit  no_idle       = 1'b0;
	bit  hold_req      = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// advance the shadow parser by one accepted byte
	task automatic parse_char(input logic [CHAR_W-1:0] c, input logic f,
			output bit got, output stamp_result_t res);
		logic [DIGIT_W-1:0] d;
		bit                 is_digit;
		int                 span;
		got        = 1'b0;
		res.year   = '0;
		res.offset = '0;
		if (f) begin
			at_pos   = '0;
			stamp_ok = 1'b1;
			year_sum = '0;
			hour_sum = '0;
			min_sum  = '0;
			west     = 1'b0;
		end
		if (at_pos >= POS_IDLE)
			return;
		d        = DIGIT_W'(c - CHAR_ZERO);
		is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		case (at_pos)
			POS_DASH_MON, POS_DASH_DAY: begin
				if (c != CHAR_MINUS)
					stamp_ok = 1'b0;
			end
			POS_T: begin
				if (c != CHAR_T)
					stamp_ok = 1'b0;
			end
			POS_COLON_M, POS_COLON_S: begin
				if (c != CHAR_COLON)
					stamp_ok = 1'b0;
			end
			POS_SIGN: begin
				if (c == CHAR_MINUS)
					west = 1'b1;
				else if (c != CHAR_PLUS)
					stamp_ok = 1'b0;
			end
			default: begin
				// a non-digit only spoils the shape, it is never accumulated
				if (!is_digit)
					stamp_ok = 1'b0;
				else if (at_pos < POS_YEAR_END)
					year_sum = YACC_W'(year_sum * 10 + d);
				else if (at_pos == POS_HOUR_HI || at_pos == POS_HOUR_LO)
					hour_sum = HMACC_W'(hour_sum * 10 + d);
				else if (at_pos == POS_MIN_HI || at_pos == POS_MIN_LO)
					min_sum = HMACC_W'(min_sum * 10 + d);
			end
		endcase
		at_pos = at_pos + 1'b1;
		if (at_pos != POS_IDLE)
			return;
		got = 1'b1;
		if (stamp_ok && year_sum >= YEAR_MIN && year_sum <= YEAR_MAX) begin
			res.year = year_sum[YEAR_W-1:0];
			span     = hour_sum * 60 + min_sum;
			if (span <= int'(OFFSET_MAX))
				res.offset = OFFSET_W'(west ? -span : span);
		end
	endtask

	// offer one byte, wait for the transaction, then record what it should cause
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic f,
			input bit typed = 1'b0, input int typed_year = 0, input int typed_offset = 0);
		int            gap;
		bit            got;
		stamp_result_t res;
		gap = no_idle ? 0 : gap_len();
		repeat (gap) begin
			@(negedge clk);
			chars_if.valid <= 1'b0;
		end
		@(negedge clk);
		chars_if.valid      <= 1'b1;
		chars_if.char_byte  <= c;
		chars_if.first_byte <= f;
		do
			@(posedge clk);
		while (!chars_if.ready);
		chars_sent++;
		parse_char(c, f, got, res);
		if (got) begin
			if (typed) begin
				res.year   = YEAR_W'(typed_year);
				res.offset = OFFSET_W'(typed_offset);
			end
			pending_stamps.push_back(res);
		end
	endtask

	// drop valid before any wait that is not a handshake
	task automatic release_bus();
		@(negedge clk);
		chars_if.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		release_bus();
		while (pending_stamps.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_digits(input int pos, input int n, input int val);
		for (int i = n - 1; i >= 0; i--) begin
			stamp_buf[pos + i] = CHAR_ZERO + CHAR_W'(val % 10);
			val = val / 10;
		end
	endtask

	// well-formed timestamp with random content, sometimes one byte spoiled
	task automatic build_stamp();
		int year;
		int hours;
		int mins;
		year = ($urandom_range(0, 9) < 7) ? $urandom_range(1995, 2205) : $urandom_range(0, 9999);
		put_digits(0, 4, year);
		stamp_buf[4]  = CHAR_MINUS;
		put_digits(5, 2, $urandom_range(1, 12));
		stamp_buf[7]  = CHAR_MINUS;
		put_digits(8, 2, $urandom_range(1, 31));
		stamp_buf[10] = CHAR_T;
		put_digits(11, 2, $urandom_range(0, 23));
		stamp_buf[13] = CHAR_COLON;
		put_digits(14, 2, $urandom_range(0, 59));
		stamp_buf[16] = CHAR_COLON;
		put_digits(17, 2, $urandom_range(0, 59));
		stamp_buf[19] = $urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS;
		case ($urandom_range(0, 9))
			0: begin
				hours = $urandom_range(0, 99);
				mins  = $urandom_range(0, 99);
			end
			1: begin
				hours = 14;
				mins  = $urandom_range(0, 1);
			end
			default: begin
				hours = $urandom_range(0, 14);
				mins  = 15 * $urandom_range(0, 3) + $urandom_range(0, 1) * $urandom_range(0, 14);
			end
		endcase
		put_digits(20, 2, hours);
		put_digits(22, 2, mins);
		if ($urandom_range(0, 7) == 0)
			stamp_buf[$urandom_range(0, STAMP_LEN - 1)] = CHAR_W'($urandom_range(0, 255));
	endtask

	task automatic send_stamp(input int len);
		for (int i = 0; i < len; i++)
			send_char(stamp_buf[i], i == 0);
		stamp_chars += len;
		if (len == STAMP_LEN)
			stamps_sent++;
	endtask

	task automatic send_noise(input int n, input bit any_first);
		for (int i = 0; i < n; i++)
			send_char(CHAR_W'($urandom_range(0, 255)),
				any_first ? 1'($urandom_range(0, 1)) : 1'b0);
	endtask

	// hold the output back while whole timestamps keep coming, so the input backs up
	task automatic squeeze();
		hold_req = 1'b1;
		no_idle  = 1'b1;
		squeezes++;
		for (int k = 0; k < 4; k++) begin
			build_stamp();
			send_stamp(STAMP_LEN);
		end
		no_idle = 1'b0;
	endtask

	// result side: random stalls, idle-free stretches, and a long hold on request
	initial begin
		int hold_left;
		int stall_left;
		int run_left;
		hold_left       = 0;
		stall_left      = 0;
		run_left        = 0;
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				result_if.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				result_if.ready <= 1'b0;
				stall_left--;
			end else begin
				result_if.ready <= 1'b1;
				if (run_left > 0) begin
					run_left--;
				end else begin
					stall_left = no_idle ? 0 : gap_len();
					run_left   = $urandom_range(0, 6);
				end
			end
		end
	end

	// compare every result transaction with the oldest pending timestamp
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_stamps.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got year %0d offset %0d",
					$time, result_if.year_value, result_if.offset_minutes);
			end else begin
				oldest = pending_stamps.pop_front();
				results_seen++;
				if (result_if.year_value !== oldest.year) begin
					errors++;
					$display("%0t: year_value expected %0d got %0d",
						$time, oldest.year, result_if.year_value);
				end
				if (result_if.offset_minutes !== oldest.offset) begin
					errors++;
					$display("%0t: offset_minutes expected %0d got %0d",
						$time, oldest.offset, result_if.offset_minutes);
				end
			end
		end
	end

	// watchdog
	initial begin
		#RUN_LIMIT;
		$display("%0t: timeout with %0d results pending", $time, pending_stamps.size());
		$display("status: fail");
		$finish;
	end

	// stimulus
	initial begin
		int kind;
		int since_pause;
		arst_n              = 1'b0;
		chars_if.valid      = 1'b0;
		chars_if.char_byte  = '0;
		chars_if.first_byte = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (stamp_rows[r]) begin
			for (int i = 0; i < stamp_rows[r].text.len(); i++)
				send_char(stamp_rows[r].text[i], stamp_rows[r].lead_first && i == 0,
					stamp_rows[r].typed, stamp_rows[r].year, stamp_rows[r].offset);
		end
		wait_drained();

		// random part, opening with a backed-up output
		squeeze();
		since_pause = 0;
		while (chars_sent < RANDOM_CHARS) begin
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				send_noise($urandom_range(1, 6), 1'b0);
			end else if (kind == 1) begin
				send_noise($urandom_range(1, 4), 1'b1);
			end else if (kind == 2) begin
				// cut short, the next first flag restarts the parse
				build_stamp();
				send_stamp($urandom_range(1, STAMP_LEN - 1));
			end else begin
				build_stamp();
				send_stamp(STAMP_LEN);
				if ($urandom_range(0, 5) == 0)
					send_noise($urandom_range(1, 3), 1'b0);
			end
			since_pause++;
			if (since_pause == 20) begin
				since_pause = 0;
				case ($urandom_range(0, 3))
					0: wait_drained();
					1: squeeze();
					2: no_idle = ~no_idle;
					default: ;
				endcase
			end
		end
		no_idle = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d bytes (%0d in random timestamps), %0d full timestamps",
			chars_sent, stamp_chars, stamps_sent);
		$display("after %0d directed rows, %0d results; output held off for %0d cycles %0d times",
			NUM_ROWS, results_seen, HOLD_CYCLES, squeezes);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/its_pkg.sv
src/its_if.sv
src/its_front.sv
src/its_queue.sv
src/its_back.sv
src/iso_timestamp_year_offset_parser.sv
tb/iso_timestamp_year_offset_parser_tb.sv
